### hw/rtl/pcmo_pkg.sv
// pcmo_pkg: shared constants, codes and types of the PCM-out descriptor DMA channel.
// Depends on nothing; the front, queue, back and top files refer to it by scoped names.
`default_nettype none

package pcmo_pkg;

   // default sizes
   localparam int RING_ENTRIES_DEF = 32;
   localparam int QUEUE_DEPTH_DEF  = 4;

   // input actions
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_DESC   = 2'd2;
   localparam logic [1:0] ACT_TICK   = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_DESC   = 2'd2;
   localparam logic [1:0] KIND_SAMPLE = 2'd3;

   // channel register offsets
   localparam logic [3:0] OFF_INDEX   = 4'h4;
   localparam logic [3:0] OFF_LAST    = 4'h5;
   localparam logic [3:0] OFF_STATUS  = 4'h6;
   localparam logic [3:0] OFF_SAMPLES = 4'h8;
   localparam logic [3:0] OFF_CONTROL = 4'hB;

   // control and status bits
   localparam int CR_RUN_BIT      = 0;
   localparam int CR_RESET_BIT    = 1;
   localparam int SR_HALTED_BIT   = 0;
   localparam int SR_COMPLETE_BIT = 3;
   localparam int FLAG_IOC_BIT    = 15;

   // one result item without the per-step flags
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] read_value;
      logic [31:0] mem_address;
   } result_type;

   // everything one input item produces: one or two results and the flags after the step
   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
      logic       halted;
      logic       irq;
   } queue_entry_type;

endpackage

`default_nettype wire

### hw/rtl/pcmo_ifs.sv
// Valid/ready channel interfaces of the PCM-out descriptor DMA channel.
// Request carries the input item, response carries one result item. No dependencies.
`default_nettype none

interface pcmo_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [3:0]  reg_offset;
   logic [15:0] write_value;
   logic [31:0] entry_address;
   logic [15:0] entry_samples;
   logic [15:0] entry_flags;

   modport source (
      output valid, action, reg_offset, write_value, entry_address, entry_samples,
             entry_flags,
      input  ready
   );
   modport sink (
      input  valid, action, reg_offset, write_value, entry_address, entry_samples,
             entry_flags,
      output ready
   );
endinterface

interface pcmo_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] read_value;
   logic [31:0] mem_address;
   logic        halted;
   logic        irq;
   logic        last;

   modport source (
      output valid, kind, read_value, mem_address, halted, irq, last,
      input  ready
   );
   modport sink (
      input  valid, kind, read_value, mem_address, halted, irq, last,
      output ready
   );
endinterface

`default_nettype wire

### hw/rtl/pcmo_front.sv
// pcmo_front: accepts request items, holds all channel state and builds the results.
// Depends on pcmo_pkg and pcmo_req_if; pushes one queue entry per accepted item.
`default_nettype none

module pcmo_front #(
   parameter int RING_ENTRIES = pcmo_pkg::RING_ENTRIES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [31:0]              csr_write_data,
   pcmo_req_if.sink                      req,
   input  wire logic                     queue_full,
   output logic                          push_valid,
   output pcmo_pkg::queue_entry_type     push_entry
);

   localparam int IW = $clog2(RING_ENTRIES);
   localparam logic [IW-1:0] LastIdx = IW'(RING_ENTRIES - 1);
   // reciprocal for the last-index reduction: exact floor for every 16-bit value
   localparam int RecipShift = 16 + $clog2(RING_ENTRIES);
   localparam logic [63:0] RecipWide =
      ((64'd1 << RecipShift) + 64'(RING_ENTRIES) - 64'd1) / 64'(RING_ENTRIES);
   localparam logic [17:0] RecipMul = RecipWide[17:0];
   localparam logic [15:0] RingWord = 16'(RING_ENTRIES);

   // channel state
   logic [31:0]   list_base_ff, list_base_in;
   logic [IW-1:0] cur_idx_ff, cur_idx_in;
   logic [IW-1:0] lvi_ff, lvi_in;
   logic [15:0]   samples_ff, samples_in;
   logic [15:0]   buf_len_ff, buf_len_in;
   logic [31:0]   buf_addr_ff, buf_addr_in;
   logic          ent_int_ff, ent_int_in;
   logic          run_ff, run_in;
   logic          halted_ff, halted_in;
   logic          comp_ff, comp_in;
   logic          pend_ff, pend_in;

   // last-index reduction in flight
   logic          lvi_busy_ff, lvi_busy_in;
   logic [15:0]   lvi_raw_ff, lvi_raw_in;
   logic [15:0]   lvi_q_ff, lvi_q_in;

   logic          accept;
   logic [33:0]   recip_prod;
   logic [31:0]   lvi_prod;
   logic [15:0]   lvi_rem;
   logic [IW-1:0] next_idx;
   logic [31:0]   desc_cur;
   logic [31:0]   desc_next;
   logic [15:0]   played;
   logic [31:0]   sample_addr;
   logic [15:0]   samples_dec;
   logic [15:0]   read_data;
   logic          have_sample;
   logic          have_desc;
   pcmo_pkg::result_type res_ack;
   pcmo_pkg::result_type res_desc_cur;
   pcmo_pkg::result_type res_desc_next;
   pcmo_pkg::result_type res_sample;

   assign req.ready = !queue_full && !lvi_busy_ff;
   assign accept    = req.valid && req.ready;

   // quotient of the written last index by the ring size, finished next cycle
   assign recip_prod = 34'(req.write_value) * 34'(RecipMul);
   assign lvi_prod   = 32'(lvi_q_ff) * 32'(RingWord);
   assign lvi_rem    = lvi_raw_ff - lvi_prod[15:0];

   // addresses
   assign next_idx    = (cur_idx_ff == LastIdx) ? '0 : cur_idx_ff + IW'(1);
   assign desc_cur    = list_base_ff + (32'(cur_idx_ff) << 3);
   assign desc_next   = list_base_ff + (32'(next_idx) << 3);
   assign played      = buf_len_ff - samples_ff;
   assign sample_addr = buf_addr_ff + (32'(played) << 1);
   assign samples_dec = samples_ff - 16'd1;

   assign res_ack       = '{kind: pcmo_pkg::KIND_ACK, read_value: 16'd0, mem_address: 32'd0};
   assign res_desc_cur  = '{kind: pcmo_pkg::KIND_DESC, read_value: 16'd0,
                            mem_address: desc_cur};
   assign res_desc_next = '{kind: pcmo_pkg::KIND_DESC, read_value: 16'd0,
                            mem_address: desc_next};
   assign res_sample    = '{kind: pcmo_pkg::KIND_SAMPLE, read_value: 16'd0,
                            mem_address: sample_addr};

   // register read mux
   always_comb begin
      read_data = 16'd0;
      case (req.reg_offset)
         pcmo_pkg::OFF_INDEX:   read_data = 16'(cur_idx_ff);
         pcmo_pkg::OFF_LAST:    read_data = 16'(lvi_ff);
         pcmo_pkg::OFF_STATUS: begin
            read_data[pcmo_pkg::SR_HALTED_BIT]   = halted_ff;
            read_data[pcmo_pkg::SR_COMPLETE_BIT] = comp_ff;
         end
         pcmo_pkg::OFF_SAMPLES: read_data = samples_ff;
         pcmo_pkg::OFF_CONTROL: read_data[pcmo_pkg::CR_RUN_BIT] = run_ff;
         default:               read_data = 16'd0;
      endcase
   end

   // item execution and next state
   always_comb begin
      list_base_in = csr_write_enable ? csr_write_data : list_base_ff;
      cur_idx_in   = cur_idx_ff;
      lvi_in       = lvi_ff;
      samples_in   = samples_ff;
      buf_len_in   = buf_len_ff;
      buf_addr_in  = buf_addr_ff;
      ent_int_in   = ent_int_ff;
      run_in       = run_ff;
      halted_in    = halted_ff;
      comp_in      = comp_ff;
      pend_in      = pend_ff;
      lvi_busy_in  = 1'b0;
      lvi_raw_in   = lvi_raw_ff;
      lvi_q_in     = lvi_q_ff;
      have_sample  = 1'b0;
      have_desc    = 1'b0;
      push_entry   = '{first: res_ack, second: res_ack, two: 1'b0, halted: 1'b0, irq: 1'b0};

      // finish a pending last-index write
      if (lvi_busy_ff) begin
         lvi_in = lvi_rem[IW-1:0];
      end

      if (accept) begin
         case (req.action)
            pcmo_pkg::ACT_WRITE: begin
               case (req.reg_offset)
                  pcmo_pkg::OFF_LAST: begin
                     lvi_busy_in = 1'b1;
                     lvi_raw_in  = req.write_value;
                     lvi_q_in    = 16'(recip_prod >> RecipShift);
                  end
                  pcmo_pkg::OFF_STATUS: begin
                     if (req.write_value[pcmo_pkg::SR_COMPLETE_BIT]) begin
                        comp_in = 1'b0;
                     end
                  end
                  pcmo_pkg::OFF_CONTROL: begin
                     if (req.write_value[pcmo_pkg::CR_RESET_BIT]) begin
                        cur_idx_in = '0;
                        lvi_in     = '0;
                        samples_in = 16'd0;
                        comp_in    = 1'b0;
                        run_in     = 1'b0;
                        pend_in    = 1'b0;
                        halted_in  = 1'b1;
                     end else if (req.write_value[pcmo_pkg::CR_RUN_BIT]) begin
                        run_in = 1'b1;
                        if (!run_ff && halted_ff && !pend_ff) begin
                           pend_in           = 1'b1;
                           push_entry.second = res_desc_cur;
                           push_entry.two    = 1'b1;
                        end
                     end else begin
                        run_in    = 1'b0;
                        halted_in = 1'b1;
                        pend_in   = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            pcmo_pkg::ACT_READ: begin
               push_entry.first = '{kind: pcmo_pkg::KIND_READ, read_value: read_data,
                                    mem_address: 32'd0};
            end
            pcmo_pkg::ACT_DESC: begin
               if (pend_ff) begin
                  buf_addr_in = req.entry_address;
                  buf_len_in  = req.entry_samples;
                  samples_in  = req.entry_samples;
                  ent_int_in  = req.entry_flags[pcmo_pkg::FLAG_IOC_BIT];
                  pend_in     = 1'b0;
                  halted_in   = 1'b0;
               end
            end
            pcmo_pkg::ACT_TICK: begin
               if (run_ff && !halted_ff && !pend_ff) begin
                  if (samples_ff != 16'd0) begin
                     have_sample = 1'b1;
                     samples_in  = samples_dec;
                  end
                  // buffer empty after this tick
                  if (samples_ff == 16'd0 || samples_dec == 16'd0) begin
                     if (ent_int_ff) begin
                        comp_in = 1'b1;
                     end
                     if (cur_idx_ff == lvi_ff) begin
                        halted_in = 1'b1;
                     end else begin
                        cur_idx_in = next_idx;
                        pend_in    = 1'b1;
                        have_desc  = 1'b1;
                     end
                  end
               end
               if (have_sample) begin
                  push_entry.first = res_sample;
                  if (have_desc) begin
                     push_entry.second = res_desc_next;
                     push_entry.two    = 1'b1;
                  end
               end else if (have_desc) begin
                  push_entry.first = res_desc_next;
               end
            end
            default: begin
            end
         endcase
      end

      push_entry.halted = halted_in;
      push_entry.irq    = comp_in;
   end

   assign push_valid = accept;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         list_base_ff <= 32'd0;
         cur_idx_ff   <= '0;
         lvi_ff       <= '0;
         samples_ff   <= 16'd0;
         buf_len_ff   <= 16'd0;
         buf_addr_ff  <= 32'd0;
         ent_int_ff   <= 1'b0;
         run_ff       <= 1'b0;
         halted_ff    <= 1'b1;
         comp_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         lvi_busy_ff  <= 1'b0;
      end else begin
         list_base_ff <= list_base_in;
         cur_idx_ff   <= cur_idx_in;
         lvi_ff       <= lvi_in;
         samples_ff   <= samples_in;
         buf_len_ff   <= buf_len_in;
         buf_addr_ff  <= buf_addr_in;
         ent_int_ff   <= ent_int_in;
         run_ff       <= run_in;
         halted_ff    <= halted_in;
         comp_ff      <= comp_in;
         pend_ff      <= pend_in;
         lvi_busy_ff  <= lvi_busy_in;
      end
   end

   // reduction operands
   always_ff @(posedge clock) begin
      lvi_raw_ff <= lvi_raw_in;
      lvi_q_ff   <= lvi_q_in;
   end

   // a descriptor fetch only waits while the channel is running
   a_pend_needs_run: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> run_ff)
      else $error("descriptor fetch pending while run bit is clear");

   // the channel only plays while running
   a_play_needs_run: assert property (@(posedge clock) disable iff (reset)
      !halted_ff |-> run_ff)
      else $error("channel not halted while run bit is clear");

   // indexes stay inside the ring
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (lvi_ff <= LastIdx) && (cur_idx_ff <= LastIdx))
      else $error("ring index out of range");

endmodule

`default_nettype wire

### hw/rtl/pcmo_queue.sv
// pcmo_queue: short FIFO of per-item result entries between front and back.
// Depends on pcmo_pkg for the entry type.
`default_nettype none

module pcmo_queue #(
   parameter int DEPTH = pcmo_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_valid,
   input  wire pcmo_pkg::queue_entry_type push_entry,
   output logic                           full,
   input  wire logic                      pop,
   output logic                           not_empty,
   output pcmo_pkg::queue_entry_type      head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

   pcmo_pkg::queue_entry_type slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("push into full result queue");

endmodule

`default_nettype wire

### hw/rtl/pcmo_back.sv
// pcmo_back: drains queue entries onto the response channel, one result per cycle while rsp.ready is high.
// Depends on pcmo_pkg and pcmo_rsp_if.
`default_nettype none

module pcmo_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      not_empty,
   input  wire pcmo_pkg::queue_entry_type head,
   output logic                           pop,
   pcmo_rsp_if.source                     rsp
);

   logic sel_ff, sel_in;
   logic fire;
   logic is_last;
   pcmo_pkg::result_type cur;

   assign is_last = !head.two || sel_ff;
   assign cur     = sel_ff ? head.second : head.first;

   assign rsp.valid       = not_empty;
   assign rsp.kind        = cur.kind;
   assign rsp.read_value  = cur.read_value;
   assign rsp.mem_address = cur.mem_address;
   assign rsp.halted      = head.halted;
   assign rsp.irq         = head.irq;
   assign rsp.last        = is_last;

   assign fire = rsp.valid && rsp.ready;
   assign pop  = fire && is_last;

   // step to the second result of a two-result entry
   always_comb begin
      sel_in = sel_ff;
      if (fire) begin
         sel_in = !is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   // the second result of an entry follows directly after its first
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_last) |=> (rsp.valid && sel_ff && head.two))
      else $error("second result of an item lost");

endmodule

`default_nettype wire

### hw/rtl/pcm_out_descriptor_dma_channel.sv
// PCM-out descriptor DMA channel. Walks a ring of RING_ENTRIES eight-byte buffer
// descriptors starting at list_base (written on the csr port). Each request item is a
// register write, a register read, a returned descriptor or a sample tick; it yields one
// or two response items (acknowledge, read data, descriptor fetch request, sample fetch),
// each carrying the halted and completion flags after the step and a last marker. The
// front accepts one request per cycle while the result queue has room and no last-index
// reduction is in flight; the back sends one response per cycle while rsp_if.ready is high,
// so an item that yields a sample fetch plus a descriptor request, or a run write that
// starts a fetch, yields two responses, which the QUEUE_DEPTH-entry queue absorbs. A write
// to the last valid index holds req ready low while its reduction modulo RING_ENTRIES
// completes. Results are registered in the queue before they reach the response side.
// Depends on pcmo_pkg, pcmo_ifs, pcmo_front, pcmo_queue and pcmo_back.
`default_nettype none

module pcm_out_descriptor_dma_channel #(
   parameter int RING_ENTRIES = pcmo_pkg::RING_ENTRIES_DEF,
   parameter int QUEUE_DEPTH  = pcmo_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   pcmo_req_if.sink         req_if,
   pcmo_rsp_if.source       rsp_if
);

   logic                      queue_full;
   logic                      push_valid;
   pcmo_pkg::queue_entry_type push_entry;
   logic                      pop;
   logic                      not_empty;
   pcmo_pkg::queue_entry_type head;

   // request side: state and result building
   pcmo_front #(
      .RING_ENTRIES (RING_ENTRIES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_if),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   // decoupling queue
   pcmo_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   // response side
   pcmo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp       (rsp_if)
   );

endmodule

`default_nettype wire
